// ===== rtl/sirs_pkg.sv =====
package sirs_pkg;

  localparam int REG_COUNT = 255;
  localparam int ADDR_W    = $clog2(REG_COUNT);

  localparam logic [7:0] ADDR_SOFT_RESET = 8'h21;
  localparam logic [7:0] ADDR_INT_CTRL   = 8'h23;
  localparam logic [7:0] ADDR_STATUS     = 8'h27;
  localparam logic [7:0] ADDR_OUT_FIRST  = 8'h28;
  localparam logic [7:0] ADDR_OUT_LAST   = 8'h2D;
  localparam logic [7:0] PAST_END_BYTE   = 8'hFF;
  localparam logic [7:0] COUNT_MAX       = 8'hFF;

  typedef enum logic [2:0] {
    CMD_START_WRITE = 3'd0,
    CMD_START_READ  = 3'd1,
    CMD_FINISH      = 3'd2,
    CMD_WRITE_BYTE  = 3'd3,
    CMD_READ_BYTE   = 3'd4,
    CMD_TICK        = 3'd5
  } cmd_t;

endpackage

// ===== rtl/sensor_i2c_register_slave.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------
// input    | in_valid / in_stall | command[2:0], data_byte[7:0]
// output   | out_valid/out_stall | read_data[7:0], interrupt_line
//
// One request per cycle sustained while the output is not stalled; each request
// passes the input register, then the processing step that updates the state and
// the register file memory, whose registered read port feeds read_data.
// Synchronous reset clears all control state and the per-entry valid bits,
// so every register byte reads as zero until written; no clearing pass.
// A stalled output holds the processing cycle; the input register absorbs
// one more request before in_stall rises.
module sensor_i2c_register_slave (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       interrupt_line
);

  logic       in_full;
  logic [2:0] cmd_q;
  logic [7:0] data_q;
  logic       advance;
  logic       accept;

  logic [7:0] pointer;
  logic [7:0] pointer_next;
  logic [7:0] count;
  logic [7:0] count_next;
  logic       clear_pending;
  logic       clear_pending_next;
  logic       irq_enable;
  logic       irq_enable_next;
  logic       tick_enable;
  logic       tick_enable_next;
  logic       irq_level;
  logic       irq_level_next;
  logic [7:0] status;
  logic [7:0] status_next;

  logic [7:0] mem [sirs_pkg::REG_COUNT];
  logic [sirs_pkg::REG_COUNT-1:0] mem_valid;
  logic [7:0] mem_rdata;
  logic       mem_we;
  logic       mem_re;

  logic [8:0] where_rd;
  logic [8:0] where_wr;
  logic       rd_in_range;
  logic       wr_in_range;
  logic [sirs_pkg::ADDR_W-1:0] ridx;
  logic [sirs_pkg::ADDR_W-1:0] widx;

  logic [7:0] fixed_byte;
  logic [7:0] fixed_byte_next;
  logic       use_mem;
  logic       use_mem_next;
  logic [7:0] count_inc;

  assign accept   = in_valid && !in_stall;
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;

  assign where_rd    = {1'b0, pointer} + {1'b0, count};
  assign where_wr    = where_rd - 9'd1;
  assign rd_in_range = where_rd < 9'(sirs_pkg::REG_COUNT);
  assign wr_in_range = where_wr < 9'(sirs_pkg::REG_COUNT);
  assign ridx        = where_rd[sirs_pkg::ADDR_W-1:0];
  assign widx        = where_wr[sirs_pkg::ADDR_W-1:0];
  assign count_inc   = (count == sirs_pkg::COUNT_MAX) ? count : count + 8'd1;

  always_comb begin
    pointer_next       = pointer;
    count_next         = count;
    clear_pending_next = clear_pending;
    irq_enable_next    = irq_enable;
    tick_enable_next   = tick_enable;
    irq_level_next     = irq_level;
    status_next        = status;
    mem_we             = 1'b0;
    mem_re             = 1'b0;
    fixed_byte_next    = 8'h00;
    use_mem_next       = 1'b0;
    unique case (sirs_pkg::cmd_t'(cmd_q))
      sirs_pkg::CMD_START_WRITE: begin
        count_next   = 8'd0;
        pointer_next = 8'd0;
      end
      sirs_pkg::CMD_START_READ: begin
        count_next = 8'd0;
      end
      sirs_pkg::CMD_FINISH: begin
        count_next = 8'd0;
        if (clear_pending) begin
          status_next[0]     = 1'b0;
          irq_level_next     = 1'b0;
          clear_pending_next = 1'b0;
        end
      end
      sirs_pkg::CMD_WRITE_BYTE: begin
        if (count == 8'd0) begin
          pointer_next = data_q;
        end else begin
          if (wr_in_range) begin
            if (where_wr == {1'b0, sirs_pkg::ADDR_STATUS}) begin
              status_next = data_q;
            end else begin
              mem_we = 1'b1;
            end
          end
          if (count == 8'd1) begin
            if (pointer == sirs_pkg::ADDR_SOFT_RESET) begin
              if (data_q[6]) begin
                pointer_next       = 8'd0;
                clear_pending_next = 1'b0;
                tick_enable_next   = 1'b0;
              end
            end else if (pointer == sirs_pkg::ADDR_INT_CTRL) begin
              irq_enable_next  = data_q[0];
              tick_enable_next = data_q[0];
            end
          end
        end
        count_next = count_inc;
      end
      sirs_pkg::CMD_READ_BYTE: begin
        if (rd_in_range) begin
          if (where_rd == {1'b0, sirs_pkg::ADDR_STATUS}) begin
            fixed_byte_next = status;
          end else begin
            mem_re       = 1'b1;
            use_mem_next = mem_valid[ridx];
          end
          if (pointer >= sirs_pkg::ADDR_OUT_FIRST && pointer <= sirs_pkg::ADDR_OUT_LAST) begin
            clear_pending_next = 1'b1;
          end
          count_next = count_inc;
        end else begin
          fixed_byte_next = sirs_pkg::PAST_END_BYTE;
        end
      end
      sirs_pkg::CMD_TICK: begin
        if (tick_enable) begin
          irq_level_next = irq_enable && status[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      data_q <= data_byte;
    end
    if (advance) begin
      fixed_byte <= fixed_byte_next;
      use_mem    <= use_mem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      pointer       <= 8'd0;
      count         <= 8'd0;
      clear_pending <= 1'b0;
      irq_enable    <= 1'b0;
      tick_enable   <= 1'b0;
      irq_level     <= 1'b0;
      status        <= 8'd0;
      mem_valid     <= '0;
    end else begin
      if (accept) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        pointer       <= pointer_next;
        count         <= count_next;
        clear_pending <= clear_pending_next;
        irq_enable    <= irq_enable_next;
        tick_enable   <= tick_enable_next;
        irq_level     <= irq_level_next;
        status        <= status_next;
        if (mem_we) begin
          mem_valid[widx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      mem[widx] <= data_q;
    end
    if (advance && mem_re) begin
      mem_rdata <= mem[ridx];
    end
  end

  assign read_data      = use_mem ? mem_rdata : fixed_byte;
  assign interrupt_line = irq_level;

  assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("pending request lost in input register");

  assert property (@(posedge clk) disable iff (rst)
    advance && cmd_q == sirs_pkg::CMD_FINISH |=> !clear_pending)
    else $error("finish left clear pending");

  assert property (@(posedge clk) disable iff (rst)
    advance && cmd_q == sirs_pkg::CMD_WRITE_BYTE && count == 8'd1 &&
    pointer == sirs_pkg::ADDR_SOFT_RESET && data_q[6]
    |=> pointer == 8'd0 && !tick_enable && !clear_pending)
    else $error("soft reset not applied");

  assert property (@(posedge clk) disable iff (rst)
    advance && cmd_q == sirs_pkg::CMD_WRITE_BYTE && count == sirs_pkg::COUNT_MAX
    |=> count == sirs_pkg::COUNT_MAX)
    else $error("byte count wrapped");

  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(pointer) && $stable(count) && $stable(irq_level))
    else $error("state changed without a request");

endmodule

// ===== bench/tb_sensor_i2c_register_slave.sv =====
`timescale 1ns / 100ps

module tb_sensor_i2c_register_slave;

  localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [2:0] CMD_RESERVED_7 = 3'd7;
  localparam int unsigned RANDOM_REQUESTS = 1250;
  localparam int unsigned DRAIN_EVERY = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } bus_reply_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
  } bus_request_t;

  class sensor_register_scoreboard;
    logic [7:0] regs [sirs_pkg::REG_COUNT];
    logic [7:0] pointer;
    logic [7:0] count;
    bit clear_pending;
    bit irq_enable;
    bit tick_enable;
    bit irq_level;
    bus_reply_t expected_replies [$];
    int unsigned errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pointer = '0;
      count = '0;
      clear_pending = 0;
      irq_enable = 0;
      tick_enable = 0;
      irq_level = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void advance_count();
      if (count != sirs_pkg::COUNT_MAX) count++;
    endfunction

    function void note_request(logic [2:0] cmd, logic [7:0] data);
      logic [8:0] where;
      bus_reply_t reply;
      reply.read_data = 8'h00;
      case (cmd)
        sirs_pkg::CMD_START_WRITE: begin
          count = '0;
          pointer = '0;
        end
        sirs_pkg::CMD_START_READ: count = '0;
        sirs_pkg::CMD_FINISH: begin
          count = '0;
          if (clear_pending) begin
            regs[sirs_pkg::ADDR_STATUS][0] = 1'b0;
            irq_level = 0;
            clear_pending = 0;
          end
        end
        sirs_pkg::CMD_WRITE_BYTE: begin
          if (count == 8'd0) begin
            pointer = data;
          end else begin
            where = {1'b0, pointer} + {1'b0, count} - 9'd1;
            if (where < 9'(sirs_pkg::REG_COUNT)) regs[where[7:0]] = data;
            if (count == 8'd1) begin
              if (pointer == sirs_pkg::ADDR_SOFT_RESET) begin
                if (data[6]) begin
                  pointer = '0;
                  clear_pending = 0;
                  tick_enable = 0;
                end
              end else if (pointer == sirs_pkg::ADDR_INT_CTRL) begin
                irq_enable = data[0];
                tick_enable = data[0];
              end
            end
          end
          advance_count();
        end
        sirs_pkg::CMD_READ_BYTE: begin
          where = {1'b0, pointer} + {1'b0, count};
          if (where < 9'(sirs_pkg::REG_COUNT)) begin
            reply.read_data = regs[where[7:0]];
            if (pointer >= sirs_pkg::ADDR_OUT_FIRST && pointer <= sirs_pkg::ADDR_OUT_LAST)
              clear_pending = 1;
            advance_count();
          end else begin
            reply.read_data = sirs_pkg::PAST_END_BYTE;
          end
        end
        sirs_pkg::CMD_TICK: begin
          if (tick_enable) irq_level = irq_enable && regs[sirs_pkg::ADDR_STATUS][0];
        end
        default: ;
      endcase
      reply.irq = irq_level;
      expected_replies.push_back(reply);
    endfunction

    task check_result(logic [7:0] rd, logic irq);
      bus_reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply rd=%02h irq=%0b with no request outstanding", rd, irq));
      end else begin
        want = expected_replies.pop_front();
        if (rd !== want.read_data)
          report($sformatf("read_data %02h, expected %02h", rd, want.read_data));
        if (irq !== want.irq)
          report($sformatf("interrupt_line %0b, expected %0b", irq, want.irq));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] command = '0;
  logic [7:0] data_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] read_data;
  logic       interrupt_line;

  sensor_register_scoreboard shadow_regs;
  int unsigned sent_count = 0;
  int unsigned stall_left = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;

  sensor_i2c_register_slave dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_data(read_data),
    .interrupt_line(interrupt_line)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ($urandom_range(299) == 0) rx_quiet <= ~rx_quiet;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!rx_quiet && $urandom_range(3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) shadow_regs.check_result(read_data, interrupt_line);
      if (in_valid && !in_stall) shadow_regs.note_request(command, data_byte);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (tx_quiet || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_pointer();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) return sirs_pkg::ADDR_STATUS;
    if (roll < 25) return sirs_pkg::ADDR_INT_CTRL;
    if (roll < 30) return sirs_pkg::ADDR_SOFT_RESET;
    if (roll < 50)
      return 8'($urandom_range(sirs_pkg::ADDR_OUT_FIRST, sirs_pkg::ADDR_OUT_LAST));
    if (roll < 60) return 8'($urandom_range(8'hF0, 8'hFF));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_burst_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll == 0) return $urandom_range(256, 300);
    if (roll < 70) return $urandom_range(1, 4);
    return $urandom_range(5, 12);
  endfunction

  task automatic send_request(logic [2:0] cmd, logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    data_byte <= data;
    do @(posedge clk); while (in_stall);
    if (cmd <= sirs_pkg::CMD_TICK) sent_count++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow_regs.expected_replies.size() != 0);
  endtask

  task automatic run_random_transaction();
    int unsigned kind;
    int unsigned len;
    logic [7:0] ptr;
    kind = $urandom_range(99);
    ptr = pick_pointer();
    len = pick_burst_len();
    if (kind < 10) begin
      send_request(3'($urandom_range(7)), rand_byte());
    end else if (kind < 45) begin
      send_request(sirs_pkg::CMD_START_WRITE, rand_byte());
      send_request(sirs_pkg::CMD_WRITE_BYTE, ptr);
      repeat (len) send_request(sirs_pkg::CMD_WRITE_BYTE, rand_byte());
      if ($urandom_range(9) != 0) send_request(sirs_pkg::CMD_FINISH, rand_byte());
    end else if (kind < 85) begin
      send_request(sirs_pkg::CMD_START_WRITE, rand_byte());
      send_request(sirs_pkg::CMD_WRITE_BYTE, ptr);
      if ($urandom_range(1) == 0) send_request(sirs_pkg::CMD_FINISH, rand_byte());
      send_request(sirs_pkg::CMD_START_READ, rand_byte());
      repeat (len) send_request(sirs_pkg::CMD_READ_BYTE, rand_byte());
      if ($urandom_range(9) != 0) send_request(sirs_pkg::CMD_FINISH, rand_byte());
    end else begin
      repeat ($urandom_range(1, 3)) send_request(sirs_pkg::CMD_TICK, rand_byte());
    end
  endtask

  initial begin
    bus_request_t directed_seq [$];
    int unsigned next_drain;
    directed_seq = '{
      '{sirs_pkg::CMD_READ_BYTE, 8'hFF},
      '{sirs_pkg::CMD_START_WRITE, 8'h00}, '{sirs_pkg::CMD_WRITE_BYTE, sirs_pkg::ADDR_INT_CTRL},
      '{sirs_pkg::CMD_WRITE_BYTE, 8'h01}, '{sirs_pkg::CMD_FINISH, 8'h00},
      '{sirs_pkg::CMD_START_WRITE, 8'h00}, '{sirs_pkg::CMD_WRITE_BYTE, sirs_pkg::ADDR_STATUS},
      '{sirs_pkg::CMD_WRITE_BYTE, 8'hFF}, '{sirs_pkg::CMD_FINISH, 8'h00},
      '{sirs_pkg::CMD_TICK, 8'h00},
      '{sirs_pkg::CMD_START_WRITE, 8'h00},
      '{sirs_pkg::CMD_WRITE_BYTE, sirs_pkg::ADDR_OUT_FIRST},
      '{sirs_pkg::CMD_START_READ, 8'h00}, '{sirs_pkg::CMD_READ_BYTE, 8'h00},
      '{sirs_pkg::CMD_READ_BYTE, 8'h00},
      '{sirs_pkg::CMD_FINISH, 8'h00},
      '{sirs_pkg::CMD_START_WRITE, 8'h00}, '{sirs_pkg::CMD_WRITE_BYTE, 8'hFE},
      '{sirs_pkg::CMD_WRITE_BYTE, 8'h00},
      '{sirs_pkg::CMD_WRITE_BYTE, 8'hA5}, '{sirs_pkg::CMD_START_READ, 8'h00},
      '{sirs_pkg::CMD_READ_BYTE, 8'h00},
      '{sirs_pkg::CMD_READ_BYTE, 8'h00},
      '{sirs_pkg::CMD_START_WRITE, 8'h00},
      '{sirs_pkg::CMD_WRITE_BYTE, sirs_pkg::ADDR_SOFT_RESET},
      '{sirs_pkg::CMD_WRITE_BYTE, 8'h40}, '{sirs_pkg::CMD_TICK, 8'h00},
      '{CMD_RESERVED_6, 8'hFF}, '{CMD_RESERVED_7, 8'h00}
    };
    shadow_regs = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_seq[i]) send_request(directed_seq[i].cmd, directed_seq[i].data);
    drain_replies();

    sent_count = 0;
    next_drain = DRAIN_EVERY;
    while (sent_count < RANDOM_REQUESTS) begin
      if (sent_count >= next_drain) begin
        drain_replies();
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(39) == 0) tx_quiet = ~tx_quiet;
      run_random_transaction();
    end

    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow_regs.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
